>>> hw/rtl/tridiagonal_system_solver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tridiagonal solver
// Implication forms used by the solver's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH

// same-cycle implication
`define TDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// Shared constants, codes and types of the tridiagonal solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tds_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int ROW_AW    = $clog2(MAX_ROWS);
	localparam int CNT_W     = ROW_AW + 1;
	localparam int Q_W       = 32;
	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = Q_W + FRAC_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_ZERO_PIVOT = 2'd1;
	localparam logic [1:0] STATUS_SAT        = 2'd2;

	typedef enum logic [1:0] {
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_FIN
	} alu_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FDIV,
		S_FMULU,
		S_FSUBP,
		S_FMULR,
		S_FSUBR,
		S_FWR,
		S_BRD,
		S_BMUL,
		S_BSUB,
		S_BDIV,
		S_ORD,
		S_OUT
	} seq_state_t;

	typedef struct packed {
		logic                    start;
		alu_op_t                 op;
		logic signed [Q_W-1:0]   a;
		logic signed [Q_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic                    done;
		logic                    sat;
		logic                    zdiv;
		logic signed [Q_W-1:0]   result;
	} alu_rsp_t;

	typedef struct packed {
		logic signed [Q_W-1:0]   pivot;
		logic signed [Q_W-1:0]   upper;
		logic signed [Q_W-1:0]   rrhs;
	} row_data_t;

	typedef struct packed {
		logic                    row_en;
		logic                    sol_en;
		logic [ROW_AW-1:0]       addr;
		row_data_t               data;
	} store_wr_t;

endpackage

>>> hw/rtl/tds_alu.sv
// ----------------------------------------------------------------------------
// tds_alu
// Shared Q16.16 unit: saturating subtract, multiply and restoring divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tds_alu (
	input  logic            clk,
	input  logic            arst_n,
	input  tds_pkg::alu_req_t req,
	output tds_pkg::alu_rsp_t rsp
);
	import tds_pkg::*;

	alu_state_t state_q, state_d;

	logic signed [2*Q_W-1:0] prod_s1;
	logic [DIV_STEPS-1:0]    num_q;
	logic [DIV_STEPS-1:0]    quo_q;
	logic [Q_W-1:0]          den_q;
	logic [Q_W-1:0]          rem_q;
	logic                    neg_q;
	logic [DIV_CW-1:0]       cnt_q;

	logic                    done_q;
	logic                    sat_q;
	logic                    zdiv_q;
	logic signed [Q_W-1:0]   res_q;

	logic                    fin;
	logic                    sat_d;
	logic                    zdiv_d;
	logic signed [Q_W-1:0]   res_d;

	logic                    b_zero;
	logic [Q_W:0]            a_ext, b_ext;
	logic [Q_W-1:0]          a_mag, b_mag;

	logic [Q_W:0]            sub_w;
	logic                    sub_ovf;
	logic signed [Q_W-1:0]   sub_res;

	logic signed [2*Q_W-1:0] mul_adj;
	logic [DIV_STEPS-1:0]    mul_q;
	logic                    mul_ovf;
	logic signed [Q_W-1:0]   mul_res;

	logic [Q_W:0]            rem_sh;
	logic [Q_W:0]            rem_diff;
	logic                    rem_ge;
	logic                    div_ovf;
	logic signed [Q_W-1:0]   div_res;

	assign b_zero = (req.b == '0);
	assign a_ext  = {req.a[Q_W-1], req.a};
	assign b_ext  = {req.b[Q_W-1], req.b};
	assign a_mag  = req.a[Q_W-1] ? Q_W'((Q_W+1)'(0) - a_ext) : Q_W'(a_ext);
	assign b_mag  = req.b[Q_W-1] ? Q_W'((Q_W+1)'(0) - b_ext) : Q_W'(b_ext);

	assign sub_w   = a_ext - b_ext;
	assign sub_ovf = sub_w[Q_W] ^ sub_w[Q_W-1];
	assign sub_res = sub_ovf ? (sub_w[Q_W] ? Q_MIN : Q_MAX) : $signed(sub_w[Q_W-1:0]);

	// truncate toward zero before dropping the fraction
	assign mul_adj = prod_s1 + (prod_s1[2*Q_W-1] ? (2*Q_W)'(65535) : (2*Q_W)'(0));
	assign mul_q   = mul_adj[2*Q_W-1:FRAC_W];
	assign mul_ovf = !((&mul_q[DIV_STEPS-1:Q_W-1]) || (~|mul_q[DIV_STEPS-1:Q_W-1]));
	assign mul_res = mul_ovf ? (mul_q[DIV_STEPS-1] ? Q_MIN : Q_MAX)
	                         : $signed(mul_q[Q_W-1:0]);

	assign rem_sh   = {rem_q, num_q[DIV_STEPS-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = (rem_sh >= {1'b0, den_q});

	assign div_ovf = neg_q ? ((|quo_q[DIV_STEPS-1:Q_W]) || (quo_q[Q_W-1] && (|quo_q[Q_W-2:0])))
	                       : (|quo_q[DIV_STEPS-1:Q_W-1]);
	assign div_res = div_ovf ? (neg_q ? Q_MIN : Q_MAX)
	                         : (neg_q ? $signed(Q_W'(0) - quo_q[Q_W-1:0])
	                                  : $signed(quo_q[Q_W-1:0]));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						ALU_MUL: state_d = A_MUL;
						ALU_DIV: state_d = b_zero ? A_IDLE : A_DIV;
						default: state_d = A_IDLE;
					endcase
				end
			end
			A_MUL:   state_d = A_IDLE;
			A_DIV:   state_d = (cnt_q == DIV_CW'(DIV_STEPS - 1)) ? A_FIN : A_DIV;
			A_FIN:   state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_comb begin
		fin    = 1'b0;
		sat_d  = 1'b0;
		zdiv_d = 1'b0;
		res_d  = '0;
		unique case (state_q)
			A_IDLE: begin
				if (req.start && req.op == ALU_SUB) begin
					fin   = 1'b1;
					sat_d = sub_ovf;
					res_d = sub_res;
				end else if (req.start && req.op == ALU_DIV && b_zero) begin
					fin    = 1'b1;
					zdiv_d = 1'b1;
				end
			end
			A_MUL: begin
				fin   = 1'b1;
				sat_d = mul_ovf;
				res_d = mul_res;
			end
			A_FIN: begin
				fin   = 1'b1;
				sat_d = div_ovf;
				res_d = div_res;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q  <= res_d;
			sat_q  <= sat_d;
			zdiv_q <= zdiv_d;
		end
		if (state_q == A_IDLE && req.start) begin
			prod_s1 <= req.a * req.b;
			num_q   <= {a_mag, FRAC_W'(0)};
			den_q   <= b_mag;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= req.a[Q_W-1] ^ req.b[Q_W-1];
		end else if (state_q == A_DIV) begin
			rem_q <= rem_ge ? rem_diff[Q_W-1:0] : rem_sh[Q_W-1:0];
			num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_STEPS-2:0], rem_ge};
			cnt_q <= cnt_q + DIV_CW'(1);
		end
	end

	assign rsp.done   = done_q;
	assign rsp.sat    = sat_q;
	assign rsp.zdiv   = zdiv_q;
	assign rsp.result = res_q;

endmodule

>>> hw/rtl/tds_store.sv
// ----------------------------------------------------------------------------
// tds_store
// Row memories: pivots, super-diagonal, reduced rhs (later the solutions).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tds_store (
	input  logic                        clk,
	input  tds_pkg::store_wr_t          wr,
	input  logic                        rd_en,
	input  logic [tds_pkg::ROW_AW-1:0]  rd_addr,
	output tds_pkg::row_data_t          rd_data
);
	import tds_pkg::*;

	logic signed [Q_W-1:0] pivot_mem [MAX_ROWS];
	logic signed [Q_W-1:0] upper_mem [MAX_ROWS];
	logic signed [Q_W-1:0] rrhs_mem  [MAX_ROWS];

	row_data_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.row_en) begin
			pivot_mem[wr.addr] <= wr.data.pivot;
			upper_mem[wr.addr] <= wr.data.upper;
		end
		if (wr.row_en || wr.sol_en) begin
			rrhs_mem[wr.addr] <= wr.data.rrhs;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q.pivot <= pivot_mem[rd_addr];
			rd_q.upper <= upper_mem[rd_addr];
			rd_q.rrhs  <= rrhs_mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> hw/rtl/tridiagonal_system_solver.sv
// ----------------------------------------------------------------------------
// tridiagonal_system_solver
// Thomas-algorithm solver for signed Q16.16 tridiagonal systems.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one row per request: lower,
//   diag, upper, rhs. Forward elimination runs on each row as it arrives.
//   rows_in_use_we/rows_in_use set the system size (1..64, 0 reads as 1,
//   larger values as 64); write it only while the block is idle.
//   After the last row, back substitution runs and the output channel
//   (out_valid/out_ready) returns one request per row, last row first, with
//   row_index, last on row zero, and one status for the whole solve.
//   Row zero is only accepted and written to the store; each later row also
//   runs a divide, two multiplies and two subtracts, mostly in the 48-step
//   restoring divide of the shared arithmetic unit. Back substitution reads,
//   multiplies, subtracts and divides per row (last row: read and divide),
//   then each result is a registered memory read, held until taken.
//   in_ready is low from acceptance of a row until its elimination is done,
//   and from the final row until its last result is taken.
//   A stalled receiver simply holds the current result; nothing is lost.
//   Reset: size returns to 64, no rows loaded, status flags clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tridiagonal_system_solver_assert.svh"

module tridiagonal_system_solver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rows_in_use_we,
	input  logic [tds_pkg::CNT_W-1:0]     rows_in_use,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            lower,
	input  logic signed [31:0]            diag,
	input  logic signed [31:0]            upper,
	input  logic signed [31:0]            rhs,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            solution,
	output logic [tds_pkg::ROW_AW-1:0]    row_index,
	output logic                          last,
	output logic [1:0]                    status
);
	import tds_pkg::*;

	seq_state_t state_q, state_d;

	logic [CNT_W-1:0]      n_cfg_q;
	logic [ROW_AW-1:0]     rows_loaded_q;
	logic [ROW_AW-1:0]     idx_q;
	logic [ROW_AW-1:0]     top_q;
	logic                  issued_q;
	logic [1:0]            flags_q;

	logic signed [Q_W-1:0] lo_q, dg_q, up_q, rh_q;
	logic signed [Q_W-1:0] m_q, tmp_q, x_q, piv_q, rrhs_q;
	logic signed [Q_W-1:0] prev_piv_q, prev_up_q, prev_rrhs_q;

	alu_req_t              alu_req;
	alu_rsp_t              alu_rsp;
	store_wr_t             st_wr;
	row_data_t             st_rd;
	logic                  st_rd_en;

	logic                  in_acc;
	logic                  out_acc;
	logic                  arith;
	logic                  done;
	logic [CNT_W-1:0]      n_eff;
	logic [CNT_W-1:0]      count;
	logic                  more_rows;

	tds_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	tds_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.rd_en   (st_rd_en),
		.rd_addr (idx_q),
		.rd_data (st_rd)
	);

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign done      = alu_rsp.done;
	assign n_eff     = (n_cfg_q == '0) ? CNT_W'(1)
	                 : ((n_cfg_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : n_cfg_q);
	assign count     = {1'b0, rows_loaded_q} + CNT_W'(1);
	assign more_rows = (count < n_eff);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_acc) state_d = (rows_loaded_q == '0) ? S_FWR : S_FDIV;
			S_FDIV:  if (done) state_d = S_FMULU;
			S_FMULU: if (done) state_d = S_FSUBP;
			S_FSUBP: if (done) state_d = S_FMULR;
			S_FMULR: if (done) state_d = S_FSUBR;
			S_FSUBR: if (done) state_d = S_FWR;
			S_FWR:   state_d = more_rows ? S_IDLE : S_BRD;
			S_BRD:   state_d = (idx_q == top_q) ? S_BDIV : S_BMUL;
			S_BMUL:  if (done) state_d = S_BSUB;
			S_BSUB:  if (done) state_d = S_BDIV;
			S_BDIV:  if (done) state_d = (idx_q == '0) ? S_ORD : S_BRD;
			S_ORD:   state_d = S_OUT;
			S_OUT:   if (out_acc) state_d = (idx_q == '0) ? S_IDLE : S_ORD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		arith       = 1'b0;
		alu_req.op  = ALU_SUB;
		alu_req.a   = '0;
		alu_req.b   = '0;
		st_rd_en    = 1'b0;
		st_wr       = '0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_FDIV: begin
				arith      = 1'b1;
				alu_req.op = ALU_DIV;
				alu_req.a  = lo_q;
				alu_req.b  = prev_piv_q;
			end
			S_FMULU: begin
				arith      = 1'b1;
				alu_req.op = ALU_MUL;
				alu_req.a  = m_q;
				alu_req.b  = prev_up_q;
			end
			S_FSUBP: begin
				arith      = 1'b1;
				alu_req.a  = dg_q;
				alu_req.b  = tmp_q;
			end
			S_FMULR: begin
				arith      = 1'b1;
				alu_req.op = ALU_MUL;
				alu_req.a  = m_q;
				alu_req.b  = prev_rrhs_q;
			end
			S_FSUBR: begin
				arith      = 1'b1;
				alu_req.a  = rh_q;
				alu_req.b  = tmp_q;
			end
			S_FWR: begin
				st_wr.row_en     = 1'b1;
				st_wr.addr       = rows_loaded_q;
				st_wr.data.pivot = piv_q;
				st_wr.data.upper = up_q;
				st_wr.data.rrhs  = rrhs_q;
			end
			S_BRD: st_rd_en = 1'b1;
			S_BMUL: begin
				arith      = 1'b1;
				alu_req.op = ALU_MUL;
				alu_req.a  = st_rd.upper;
				alu_req.b  = x_q;
			end
			S_BSUB: begin
				arith      = 1'b1;
				alu_req.a  = st_rd.rrhs;
				alu_req.b  = tmp_q;
			end
			S_BDIV: begin
				arith           = 1'b1;
				alu_req.op      = ALU_DIV;
				alu_req.a       = (idx_q == top_q) ? st_rd.rrhs : tmp_q;
				alu_req.b       = st_rd.pivot;
				st_wr.sol_en    = done;
				st_wr.addr      = idx_q;
				st_wr.data.rrhs = alu_rsp.result;
			end
			S_ORD: st_rd_en = 1'b1;
			S_OUT: out_valid = 1'b1;
			default: in_ready = 1'b0;
		endcase
		alu_req.start = arith && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			n_cfg_q       <= CNT_W'(MAX_ROWS);
			rows_loaded_q <= '0;
			idx_q         <= '0;
			top_q         <= '0;
			issued_q      <= 1'b0;
			flags_q       <= '0;
		end else begin
			state_q <= state_d;
			if (rows_in_use_we) begin
				n_cfg_q <= rows_in_use;
			end
			if (alu_req.start) begin
				issued_q <= 1'b1;
			end else if (done) begin
				issued_q <= 1'b0;
			end
			if (done) begin
				flags_q <= flags_q | {alu_rsp.sat, alu_rsp.zdiv};
			end
			if (state_q == S_FWR) begin
				if (more_rows) begin
					rows_loaded_q <= count[ROW_AW-1:0];
				end else begin
					rows_loaded_q <= '0;
					top_q         <= rows_loaded_q;
					idx_q         <= rows_loaded_q;
				end
			end
			if (state_q == S_BDIV && done) begin
				idx_q <= (idx_q == '0) ? top_q : idx_q - ROW_AW'(1);
			end
			if (out_acc) begin
				if (idx_q == '0) begin
					flags_q <= '0;
				end else begin
					idx_q <= idx_q - ROW_AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lo_q   <= lower;
			dg_q   <= diag;
			up_q   <= upper;
			rh_q   <= rhs;
			piv_q  <= diag;
			rrhs_q <= rhs;
		end
		if (done) begin
			unique case (state_q)
				S_FDIV:                          m_q    <= alu_rsp.result;
				S_FMULU, S_FMULR, S_BMUL, S_BSUB: tmp_q <= alu_rsp.result;
				S_FSUBP:                         piv_q  <= alu_rsp.result;
				S_FSUBR:                         rrhs_q <= alu_rsp.result;
				S_BDIV:                          x_q    <= alu_rsp.result;
				default:                         m_q    <= m_q;
			endcase
		end
		if (state_q == S_FWR) begin
			prev_piv_q  <= piv_q;
			prev_up_q   <= up_q;
			prev_rrhs_q <= rrhs_q;
		end
	end

	assign solution  = st_rd.rrhs;
	assign row_index = idx_q;
	assign last      = (idx_q == '0);
	assign status    = flags_q[0] ? STATUS_ZERO_PIVOT
	                 : (flags_q[1] ? STATUS_SAT : STATUS_OK);

	`TDS_ASSERT_IMPL(a_ready_out_excl, clk, arst_n, in_ready, !out_valid, "row taken while result pending")
	`TDS_ASSERT_IMPL(a_done_issued, clk, arst_n, alu_rsp.done, issued_q, "arithmetic result without request")
	`TDS_ASSERT_NEXT(a_last_idle, clk, arst_n, out_valid && out_ready && last, in_ready && rows_loaded_q == '0, "solver not cleared after final result")
	`TDS_ASSERT_IMPL(a_row_range, clk, arst_n, out_valid, row_index <= top_q, "result row beyond system size")

endmodule

>>> test/tds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_checker
// Watches the size, row and solution ports of the tridiagonal solver. Runs its
// own Q16.16 Thomas elimination on every accepted row and compares each
// solution request, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tds_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rows_in_use_we,
	input  logic [tds_pkg::CNT_W-1:0]     rows_in_use,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [31:0]            lower,
	input  logic signed [31:0]            diag,
	input  logic signed [31:0]            upper,
	input  logic signed [31:0]            rhs,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [31:0]            solution,
	input  logic [tds_pkg::ROW_AW-1:0]    row_index,
	input  logic                          last,
	input  logic [1:0]                    status,
	output int                            fail_count,
	output int                            pending,
	output int                            checked
);
	import tds_pkg::*;

	typedef struct {
		logic signed [Q_W-1:0] value;
		logic [ROW_AW-1:0]     row;
		logic                  last;
		logic [1:0]            status;
	} solution_t;

	solution_t             solutions_due[$];
	logic signed [Q_W-1:0] pivots [MAX_ROWS];
	logic signed [Q_W-1:0] uppers [MAX_ROWS];
	logic signed [Q_W-1:0] reduced_rhs [MAX_ROWS];
	logic [CNT_W-1:0]      size_setting;
	logic [1:0]            flags;
	int                    rows_held;
	int                    mismatches = 0;
	int                    matched = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 40)
			$display("%0t mismatch, %s: got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// saturate to Q16.16, noting it in the flags
	function automatic logic signed [Q_W-1:0] fx_clip(input longint v);
		if (v > longint'(Q_MAX)) begin
			flags[1] = 1'b1;
			return Q_MAX;
		end
		if (v < longint'(Q_MIN)) begin
			flags[1] = 1'b1;
			return Q_MIN;
		end
		return v[Q_W-1:0];
	endfunction

	function automatic logic signed [Q_W-1:0] fx_mul(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		return fx_clip((longint'(a) * longint'(b)) / 65536);
	endfunction

	function automatic logic signed [Q_W-1:0] fx_div(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		if (b == 0) begin
			flags[0] = 1'b1;
			return '0;
		end
		return fx_clip((longint'(a) * 65536) / longint'(b));
	endfunction

	function automatic logic signed [Q_W-1:0] fx_sub(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		return fx_clip(longint'(a) - longint'(b));
	endfunction

	// forward step for one row; on the closing row, back substitution
	task automatic eliminate_row(input logic signed [Q_W-1:0] lo, input logic signed [Q_W-1:0] dg,
			input logic signed [Q_W-1:0] up, input logic signed [Q_W-1:0] rh);
		logic signed [Q_W-1:0] m;
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] answers [MAX_ROWS];
		logic [1:0]            verdict;
		solution_t             s;
		int                    size;
		int                    count;
		size = (size_setting == 0) ? 1 : (size_setting > MAX_ROWS) ? MAX_ROWS : int'(size_setting);
		if (rows_held == 0) begin
			pivots[0] = dg;
			reduced_rhs[0] = rh;
		end else begin
			m = fx_div(lo, pivots[rows_held-1]);
			pivots[rows_held] = fx_sub(dg, fx_mul(m, uppers[rows_held-1]));
			reduced_rhs[rows_held] = fx_sub(rh, fx_mul(m, reduced_rhs[rows_held-1]));
		end
		uppers[rows_held] = up;
		count = rows_held + 1;
		if (count < size) begin
			rows_held = count;
			return;
		end
		x = '0;
		for (int i = count - 1; i >= 0; i--) begin
			if (i == count - 1)
				x = fx_div(reduced_rhs[i], pivots[i]);
			else
				x = fx_div(fx_sub(reduced_rhs[i], fx_mul(uppers[i], x)), pivots[i]);
			answers[i] = x;
		end
		verdict = flags[0] ? STATUS_ZERO_PIVOT : (flags[1] ? STATUS_SAT : STATUS_OK);
		for (int i = count - 1; i >= 0; i--) begin
			s.value = answers[i];
			s.row = ROW_AW'(i);
			s.last = (i == 0);
			s.status = verdict;
			solutions_due.push_back(s);
		end
		rows_held = 0;
		flags = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		solution_t want;
		if (!arst_n) begin
			size_setting = CNT_W'(MAX_ROWS);
			rows_held = 0;
			flags = '0;
			solutions_due.delete();
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (solutions_due.size() == 0) begin
					report_mismatch($sformatf("result for row %0d with nothing expected", row_index),
						solution, 0);
				end else begin
					want = solutions_due.pop_front();
					if (solution !== want.value)
						report_mismatch($sformatf("solution of row %0d", want.row), solution, want.value);
					if (row_index !== want.row)
						report_mismatch("row index", row_index, want.row);
					if (last !== want.last)
						report_mismatch($sformatf("last flag of row %0d", want.row), last, want.last);
					if (status !== want.status)
						report_mismatch($sformatf("status of row %0d", want.row), status, want.status);
					matched++;
				end
			end
			if (in_valid && in_ready)
				eliminate_row(lower, diag, upper, rhs);
			if (rows_in_use_we)
				size_setting = rows_in_use;
			fail_count <= mismatches;
			pending <= solutions_due.size();
			checked <= matched;
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives rows and size settings into the tridiagonal solver with random
// gaps and result back-pressure: a directed set of edge systems, then random
// systems of mixed conditioning. The checker beside the block does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import tds_pkg::*;

	localparam int ONE           = 1 << FRAC_W;
	localparam int SETTLE_CYCLES = 100;
	localparam int IDLE_LIMIT    = 20000;
	localparam int RANDOM_ROWS   = 300;

	typedef enum {
		ROWS_WELL,
		ROWS_NOISE,
		ROWS_SMALL,
		ROWS_EDGY
	} row_kind_t;

	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] dg;
		logic signed [31:0] up;
		logic signed [31:0] rh;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  rows_in_use_we = 1'b0;
	logic [CNT_W-1:0]      rows_in_use = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [31:0]    lower = '0;
	logic signed [31:0]    diag = '0;
	logic signed [31:0]    upper = '0;
	logic signed [31:0]    rhs = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [31:0]    solution;
	logic [ROW_AW-1:0]     row_index;
	logic                  last;
	logic [1:0]            status;
	int                    fail_count;
	int                    pending;
	int                    checked;
	int                    rows_sent = 0;
	int                    systems = 0;
	bit                    calm = 1'b0;

	tridiagonal_system_solver DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.rows_in_use_we (rows_in_use_we),
		.rows_in_use    (rows_in_use),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.lower          (lower),
		.diag           (diag),
		.upper          (upper),
		.rhs            (rhs),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.solution       (solution),
		.row_index      (row_index),
		.last           (last),
		.status         (status)
	);

	tds_checker solve_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [31:0] edgy_value();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return ONE;
			4: return -ONE;
			default: return $urandom();
		endcase
	endfunction

	function automatic row_t make_row(input row_kind_t kind);
		row_t r;
		int   mag;
		int   side;
		r.lo = $urandom();
		r.dg = $urandom();
		r.up = $urandom();
		r.rh = $urandom();
		case (kind)
			ROWS_WELL: begin
				// diagonally dominant, so solutions stay in range
				mag = $urandom_range(2 * ONE, 64 * ONE);
				side = mag / 4;
				r.dg = ($urandom_range(0, 1) != 0) ? -mag : mag;
				r.lo = int'($urandom_range(0, 2 * side)) - side;
				r.up = int'($urandom_range(0, 2 * side)) - side;
				r.rh = int'($urandom_range(0, 256 * ONE)) - 128 * ONE;
			end
			ROWS_SMALL: begin
				r.lo = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
				r.dg = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
				r.up = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
				r.rh = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
			end
			ROWS_EDGY: begin
				r.lo = edgy_value();
				r.dg = edgy_value();
				r.up = edgy_value();
				r.rh = edgy_value();
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic row_kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return ROWS_WELL;
		if (roll < 80)
			return ROWS_NOISE;
		if (roll < 90)
			return ROWS_SMALL;
		return ROWS_EDGY;
	endfunction

	// hold the request until taken, then maybe drop valid for a gap
	task automatic send_row(input logic signed [31:0] lo, input logic signed [31:0] dg,
			input logic signed [31:0] up, input logic signed [31:0] rh);
		int gap;
		in_valid <= 1'b1;
		lower <= lo;
		diag <= dg;
		upper <= up;
		rhs <= rh;
		do @(posedge clk); while (!in_ready);
		rows_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rows(input int count, input row_kind_t kind);
		row_t r;
		repeat (count) begin
			r = make_row(kind);
			send_row(r.lo, r.dg, r.up, r.rh);
		end
	endtask

	// wait for all predicted results, then let any elimination finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rows(input int value);
		rows_in_use_we <= 1'b1;
		rows_in_use <= CNT_W'(value);
		@(posedge clk);
		rows_in_use_we <= 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: %0d cycles without a request", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		row_kind_t kind;
		int        target;
		int        size;
		int        held_size;
		int        cut;
		int        shrunk;
		int        roll;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-row systems, size 1 and size 0
		set_rows(1);
		send_row(Q_MIN, 2 * ONE, Q_MAX, 3 * ONE);
		settle();
		set_rows(0);
		send_row(0, 1, 0, Q_MAX);
		send_row(ONE, 0, ONE, ONE);
		send_row(Q_MAX, Q_MIN, Q_MIN, Q_MIN);
		systems += 4;

		// zero pivot on row zero, then zero pivot together with saturation
		settle();
		set_rows(2);
		send_row(-ONE, 0, ONE, ONE);
		send_row(ONE, ONE, -ONE, ONE);
		send_row(0, 0, Q_MAX, ONE);
		send_row(Q_MIN, 1, 0, Q_MAX);
		systems += 2;

		settle();
		set_rows(3);
		send_row(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		send_row(Q_MIN, Q_MIN, Q_MAX, Q_MIN);
		send_row(Q_MAX, Q_MAX, Q_MAX, Q_MIN);
		systems++;

		settle();
		set_rows(4);
		send_row(0, 4 * ONE, -ONE, ONE);
		send_row(-ONE, 4 * ONE, -ONE, 2 * ONE);
		send_row(-ONE, 4 * ONE, -ONE, -3 * ONE);
		send_row(-ONE, 4 * ONE, 0, ONE / 2);
		systems++;

		// size above range, then lowered below the rows already in
		settle();
		set_rows(127);
		send_rows(3, ROWS_WELL);
		settle();
		set_rows(1);
		send_rows(1, ROWS_WELL);
		systems++;
		held_size = 1;

		settle();
		set_rows(MAX_ROWS);
		send_rows(MAX_ROWS, ROWS_WELL);
		systems++;
		held_size = MAX_ROWS;

		target = rows_sent + RANDOM_ROWS - MAX_ROWS;
		while (rows_sent < target) begin
			calm = ($urandom_range(0, 3) == 0);
			kind = pick_kind();
			roll = $urandom_range(0, 99);
			if (roll < 55)
				size = $urandom_range(1, 6);
			else if (roll < 85)
				size = $urandom_range(7, 16);
			else
				size = $urandom_range(17, 40);
			if (size != held_size || $urandom_range(0, 2) == 0) begin
				settle();
				set_rows((size == 1 && $urandom_range(0, 1) != 0) ? 0 : size);
				held_size = size;
			end
			if (size >= 3 && $urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, size - 2);
				send_rows(cut, kind);
				settle();
				shrunk = $urandom_range(0, cut);
				set_rows(shrunk);
				held_size = (shrunk == 0) ? 1 : shrunk;
				send_rows(1, kind);
			end else begin
				send_rows(size, kind);
			end
			systems++;
		end
		calm = 1'b0;

		settle();
		$display("%0d rows in %0d systems, %0d solutions checked", rows_sent, systems, checked);
		$display("sizes 1 to 64 incl. settings 0 and 127, shortened systems, zero pivots, saturation");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tds_pkg.sv
hw/rtl/tds_alu.sv
hw/rtl/tds_store.sv
hw/rtl/tridiagonal_system_solver.sv
test/tds_checker.sv
test/tb_top.sv
